@@ sv/heap_sorter_top_macros.svh @@
// Assertion macros of the heap sorter top level.
`ifndef HEAP_SORTER_TOP_MACROS_SVH
`define HEAP_SORTER_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define HS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define HS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hs_pkg.sv @@
// Shared types and constants of the heap sorter.
`timescale 1ns / 1ps

package hs_pkg;

    localparam int DATA_W = 32;

    // Datapath operation requested by the controller for the current cycle.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_B_NEXT,
        OP_KEY,
        OP_SIFT_L,
        OP_SIFT_R,
        OP_SIFT_CMP,
        OP_X_NEXT,
        OP_X_TOP,
        OP_X_KEY,
        OP_X_PUT,
        OP_O_RD,
        OP_O_LOAD
    } hs_op_t;

    typedef struct packed {
        hs_op_t op;
    } hs_cmd_t;

    typedef struct packed {
        logic i_zero;     // loop index has reached zero
        logic lc_over;    // left child lies beyond the heap bound
        logic rc_ok;      // right child lies inside the heap bound
        logic descend_r;  // key is below the only child
        logic descend_c;  // key is below the larger of two children
        logic out_free;   // result register can take a word this cycle
        logic out_last;   // word being read is the last one of the run
    } hs_status_t;

endpackage

@@ sv/hs_datapath.sv @@
// Heap sorter datapath: element memory, sift registers and result register.
`timescale 1ns / 1ps

module hs_datapath #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hs_pkg::hs_cmd_t                  cmd,
    output hs_pkg::hs_status_t               stat,
    input  logic signed [hs_pkg::DATA_W-1:0] value,
    input  logic                             last,
    output logic signed [hs_pkg::DATA_W-1:0] sorted_value,
    output logic                             final_res,
    output logic                             overflow,
    output logic                             result_valid,
    input  logic                             result_ready
);
    import hs_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

    logic [DATA_W-1:0]        mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;

    logic [CW-1:0]            count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic                     res_valid_reg, res_valid_next;
    logic [CW-1:0]            n_reg, n_next;
    logic [AW-1:0]            i_reg, i_next;
    logic [AW-1:0]            hole_reg, hole_next;
    logic [AW-1:0]            bound_reg, bound_next;
    logic [AW-1:0]            k_reg, k_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] lcv_reg, lcv_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    logic                     res_final_reg, res_final_next;
    logic                     res_ovf_reg, res_ovf_next;

    logic [IW-1:0]            lc;
    logic [IW-1:0]            rc;
    logic [IW-1:0]            bound_ext;
    logic                     take_r;
    logic signed [DATA_W-1:0] big_val;
    logic [AW-1:0]            big_idx;
    logic [CW-1:0]            load_count;

    // Child indices of the vacant node.
    assign lc        = {1'b0, hole_reg, 1'b1};
    assign rc        = lc + IW'(1);
    assign bound_ext = IW'(bound_reg);

    assign take_r  = lcv_reg < rd_data_reg;
    assign big_val = take_r ? rd_data_reg : lcv_reg;
    assign big_idx = take_r ? rc[AW-1:0] : lc[AW-1:0];

    assign load_count = (count_reg != MAX_CNT) ? count_reg + CW'(1) : count_reg;

    always_comb
    begin
        stat.i_zero    = (i_reg == '0);
        stat.lc_over   = (lc > bound_ext);
        stat.rc_ok     = (lc < bound_ext);
        stat.descend_r = (key_reg < rd_data_reg);
        stat.descend_c = (key_reg < big_val);
        stat.out_free  = !res_valid_reg || result_ready;
        stat.out_last  = (CW'(k_reg) == n_reg - CW'(1));
    end

    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = hole_reg;
        wr_data        = key_reg;
        rd_en          = 1'b0;
        rd_addr        = lc[AW-1:0];
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        hole_next      = hole_reg;
        bound_next     = bound_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        lcv_next       = lcv_reg;
        top_next       = top_reg;
        res_value_next = res_value_reg;
        res_final_next = res_final_reg;
        res_ovf_next   = res_ovf_reg;
        res_valid_next = res_valid_reg && !result_ready;

        case (cmd.op)
            OP_LOAD:
            begin
                if (count_reg != MAX_CNT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[AW-1:0];
                    wr_data = value;
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                count_next = load_count;
                if (last)
                begin
                    n_next = load_count;
                    i_next = AW'(load_count >> 1);
                end
            end
            OP_B_NEXT:
            begin
                if (i_reg != '0)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg - AW'(1);
                    hole_next  = i_reg - AW'(1);
                    i_next     = i_reg - AW'(1);
                    bound_next = AW'(n_reg - CW'(1));
                end
                else
                begin
                    i_next = AW'(n_reg - CW'(1));
                end
            end
            OP_KEY:
            begin
                key_next = rd_data_reg;
            end
            OP_SIFT_L:
            begin
                if (lc > bound_ext)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = lc[AW-1:0];
                end
            end
            OP_SIFT_R:
            begin
                lcv_next = rd_data_reg;
                if (lc < bound_ext)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rc[AW-1:0];
                end
                else if (key_reg < rd_data_reg)
                begin
                    wr_en     = 1'b1;
                    wr_data   = rd_data_reg;
                    hole_next = lc[AW-1:0];
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            OP_SIFT_CMP:
            begin
                wr_en = 1'b1;
                if (key_reg < big_val)
                begin
                    wr_data   = big_val;
                    hole_next = big_idx;
                end
            end
            OP_X_NEXT:
            begin
                k_next = '0;
                if (i_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            OP_X_TOP:
            begin
                top_next = rd_data_reg;
                rd_en    = 1'b1;
                rd_addr  = i_reg;
            end
            OP_X_KEY:
            begin
                key_next   = rd_data_reg;
                hole_next  = '0;
                bound_next = i_reg - AW'(1);
            end
            OP_X_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = top_reg;
                i_next  = i_reg - AW'(1);
            end
            OP_O_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = k_reg;
            end
            OP_O_LOAD:
            begin
                if (stat.out_free)
                begin
                    res_value_next = rd_data_reg;
                    res_final_next = stat.out_last;
                    res_ovf_next   = dropped_reg;
                    res_valid_next = 1'b1;
                    k_next         = k_reg + AW'(1);
                    if (stat.out_last)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Element memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        i_reg         <= i_next;
        hole_reg      <= hole_next;
        bound_reg     <= bound_next;
        k_reg         <= k_next;
        key_reg       <= key_next;
        lcv_reg       <= lcv_next;
        top_reg       <= top_next;
        res_value_reg <= res_value_next;
        res_final_reg <= res_final_next;
        res_ovf_reg   <= res_ovf_next;
    end

    assign sorted_value = res_value_reg;
    assign final_res    = res_final_reg;
    assign overflow     = res_ovf_reg;
    assign result_valid = res_valid_reg;

endmodule

@@ sv/hs_ctrl.sv @@
// Heap sorter controller: sequences loading, heap build, extraction and output.
`timescale 1ns / 1ps

module hs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               elem_valid,
    input  logic               last,
    output logic               elem_ready,
    output hs_pkg::hs_cmd_t    cmd,
    input  hs_pkg::hs_status_t stat
);
    import hs_pkg::*;

    typedef enum logic [11:0] {
        ST_LOAD     = 12'b0000_0000_0001,
        ST_B_NEXT   = 12'b0000_0000_0010,
        ST_KEY      = 12'b0000_0000_0100,
        ST_SIFT_L   = 12'b0000_0000_1000,
        ST_SIFT_R   = 12'b0000_0001_0000,
        ST_SIFT_CMP = 12'b0000_0010_0000,
        ST_X_NEXT   = 12'b0000_0100_0000,
        ST_X_TOP    = 12'b0000_1000_0000,
        ST_X_KEY    = 12'b0001_0000_0000,
        ST_X_PUT    = 12'b0010_0000_0000,
        ST_O_RD     = 12'b0100_0000_0000,
        ST_O_LOAD   = 12'b1000_0000_0000
    } hs_state_t;

    hs_state_t state_reg, state_next;
    logic      extract_reg, extract_next;
    hs_state_t sift_exit;

    // A finished sift returns to the loop that started it.
    assign sift_exit = extract_reg ? ST_X_PUT : ST_B_NEXT;

    always_comb
    begin
        state_next   = state_reg;
        extract_next = extract_reg;
        cmd.op       = OP_IDLE;
        elem_ready   = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                elem_ready = 1'b1;
                if (elem_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (last)
                    begin
                        state_next   = ST_B_NEXT;
                        extract_next = 1'b0;
                    end
                end
            end
            ST_B_NEXT:
            begin
                cmd.op = OP_B_NEXT;
                if (stat.i_zero)
                begin
                    state_next   = ST_X_NEXT;
                    extract_next = 1'b1;
                end
                else
                begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                cmd.op     = OP_KEY;
                state_next = ST_SIFT_L;
            end
            ST_SIFT_L:
            begin
                cmd.op     = OP_SIFT_L;
                state_next = stat.lc_over ? sift_exit : ST_SIFT_R;
            end
            ST_SIFT_R:
            begin
                cmd.op = OP_SIFT_R;
                if (stat.rc_ok)
                begin
                    state_next = ST_SIFT_CMP;
                end
                else
                begin
                    state_next = stat.descend_r ? ST_SIFT_L : sift_exit;
                end
            end
            ST_SIFT_CMP:
            begin
                cmd.op     = OP_SIFT_CMP;
                state_next = stat.descend_c ? ST_SIFT_L : sift_exit;
            end
            ST_X_NEXT:
            begin
                cmd.op     = OP_X_NEXT;
                state_next = stat.i_zero ? ST_O_RD : ST_X_TOP;
            end
            ST_X_TOP:
            begin
                cmd.op     = OP_X_TOP;
                state_next = ST_X_KEY;
            end
            ST_X_KEY:
            begin
                cmd.op     = OP_X_KEY;
                state_next = ST_SIFT_L;
            end
            ST_X_PUT:
            begin
                cmd.op     = OP_X_PUT;
                state_next = ST_X_NEXT;
            end
            ST_O_RD:
            begin
                cmd.op     = OP_O_RD;
                state_next = ST_O_LOAD;
            end
            ST_O_LOAD:
            begin
                cmd.op = OP_O_LOAD;
                if (stat.out_free)
                begin
                    state_next = stat.out_last ? ST_LOAD : ST_O_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            extract_reg <= extract_next;
        end
    end

endmodule

@@ sv/heap_sorter_top.sv @@
// Heap sorter top level: controller, datapath and interface checks.
//
//  Channel   Direction  Handshake                  Fields
//  element   in         elem_valid / elem_ready    value[31:0] signed, last
//  result    out        result_valid/result_ready  sorted_value[31:0] signed, final_res,
//                                                  overflow
//
// Elements load at one word per cycle while the block is collecting a set.
// After a word with last, the sort runs with elem_ready low: each heap level of a
// sift steps through ST_SIFT_L, ST_SIFT_R and, when both children lie in the heap,
// ST_SIFT_CMP on the single registered memory read port; results then leave one
// word per pass through ST_O_RD and ST_O_LOAD. Reset clears the element count,
// the overflow flag, the controller and the result valid; the memory is not cleared.
// A stalled result holds its register; the next set loads while the last word waits.
`timescale 1ns / 1ps
`include "heap_sorter_top_macros.svh"

module heap_sorter_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             elem_valid,
    output logic                             elem_ready,
    input  logic signed [hs_pkg::DATA_W-1:0] value,
    input  logic                             last,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic signed [hs_pkg::DATA_W-1:0] sorted_value,
    output logic                             final_res,
    output logic                             overflow
);
    import hs_pkg::*;

    // Command and status between the controller and the datapath.
    hs_cmd_t    cmd;
    hs_status_t stat;

    // The controller sequences the build and extraction loops; it never touches data,
    // it only reacts to elem_valid, last and the status flags of the datapath.
    hs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .last       (last),
        .elem_ready (elem_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // The datapath holds the element memory, the vacant-node sift registers
    // and the result register that parts the sorter from its consumer.
    hs_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .value        (value),
        .last         (last),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // A word with last ends collection: the sort starts in the next cycle.
    `HS_ASSERT_NEXT(a_last_stops_input, elem_valid && elem_ready && last, !elem_ready, "input still open after last word")

    // Result words appear only out of the output load step.
    `HS_ASSERT_NOW(a_result_source, $rose(result_valid), $past(cmd.op == OP_O_LOAD), "result valid rose outside output load")

    // Loading the final word of a run reopens the input in the next cycle.
    `HS_ASSERT_NEXT(a_final_reopens, cmd.op == OP_O_LOAD && stat.out_free && stat.out_last, elem_ready, "input not reopened after final word")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the heap sorter: a heapsort predictor, a scoreboard and drivers.
`timescale 1ns / 1ps

// The scoreboard mirrors the sorter. It keeps its own copy of the element store, the
// element count and the dropped flag. Each set ends with a word marked last. At that
// word it sorts the held elements with the same heap procedure and queues one expected
// sorted word per element.
class sorted_run_board;
    typedef logic signed [hs_pkg::DATA_W-1:0] elem_t;

    typedef struct {
        elem_t sorted_value;
        logic  final_res;
        logic  overflow;
    } sorted_word_t;

    int unsigned  capacity;
    elem_t        held[];
    int unsigned  held_count;
    logic         dropped;
    sorted_word_t pending_sorted[$];
    int unsigned  errors;

    function new(int unsigned cap);
        capacity   = cap;
        held       = new[cap];
        held_count = 0;
        dropped    = 1'b0;
        errors     = 0;
    endfunction

    // Move a vacant node down from top_idx through the heap that ends at bound,
    // then drop key into the hole where it belongs.
    function void sift_hole(int unsigned top_idx, elem_t key, int unsigned bound);
        int unsigned hole;
        int unsigned lc;
        int unsigned big;
        bit          settled;
        hole    = top_idx;
        settled = 1'b0;
        while (!settled && (2 * hole + 1 <= bound)) begin
            lc  = 2 * hole + 1;
            big = lc;
            if (lc < bound && held[lc] < held[lc + 1])
                big = lc + 1;
            if (key < held[big]) begin
                held[hole] = held[big];
                hole       = big;
            end else begin
                settled = 1'b1;
            end
        end
        held[hole] = key;
    endfunction

    function void heapsort_held(int unsigned n);
        int unsigned i;
        elem_t       root;
        if (n < 2)
            return;
        for (i = n / 2; i > 0; i--)
            sift_hole(i - 1, held[i - 1], n - 1);
        for (i = n - 1; i > 0; i--) begin
            root = held[0];
            sift_hole(0, held[i], i - 1);
            held[i] = root;
        end
    endfunction

    // Called for every word accepted on the element channel.
    function void take_element(elem_t v, logic is_last);
        sorted_word_t w;
        if (held_count < capacity) begin
            held[held_count] = v;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (is_last) begin
            heapsort_held(held_count);
            for (int unsigned k = 0; k < held_count; k++) begin
                w.sorted_value = held[k];
                w.final_res    = (k + 1 == held_count);
                w.overflow     = dropped;
                pending_sorted.push_back(w);
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    // Called for every word accepted on the result channel.
    function void check_sorted_word(elem_t v, logic fin, logic ovf);
        sorted_word_t w;
        if (pending_sorted.size() == 0) begin
            note_error($sformatf("unexpected word value=%0d final_res=%0b overflow=%0b",
                                 v, fin, ovf));
            return;
        end
        w = pending_sorted.pop_front();
        if (w.sorted_value !== v || w.final_res !== fin || w.overflow !== ovf)
            note_error({$sformatf("expected value=%0d final_res=%0b overflow=%0b, ",
                                  w.sorted_value, w.final_res, w.overflow),
                        $sformatf("got value=%0d final_res=%0b overflow=%0b",
                                  v, fin, ovf)});
    endfunction

    function int unsigned pending(); return pending_sorted.size(); endfunction
endclass

module tb_top;

    localparam int          CAPACITY    = 64;
    // A correct run stays well under this limit, although every result may wait out
    // long receiver stalls.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Once nothing is expected, keep watching the result channel for stray words.
    localparam int          DRAIN_CYCLES = 200;

    typedef logic signed [hs_pkg::DATA_W-1:0] elem_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  elem_valid;
    logic  elem_ready;
    elem_t value;
    logic  last;
    logic  result_valid;
    logic  result_ready;
    elem_t sorted_value;
    logic  final_res;
    logic  overflow;

    // Idle rates in percent, changed by the stimulus between phases.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned cycle_count = 0;

    sorted_run_board board;

    heap_sorter_top #(
        .MAX_ELEMENTS(CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .elem_valid  (elem_valid),
        .elem_ready  (elem_ready),
        .value       (value),
        .last        (last),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .sorted_value(sorted_value),
        .final_res   (final_res),
        .overflow    (overflow)
    );

    // A 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // A hard stop in case the sorter hangs or a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side. The handshake is sampled right after the edge, before any register
    // of the sorter has updated. After the sample, ready for the next edge is drawn
    // from the current stall rate. Apart from its value at start, ready is changed only
    // here, with a single nonblocking write per edge.
    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                board.check_sorted_word(sorted_value, final_res, overflow);
            result_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Present one word on the element channel and hold it until it is accepted.
    // Valid is left high afterwards. The next call or the caller lowers it. This way
    // back-to-back words never see a lower and a raise on the same edge.
    task automatic send_element(input elem_t v, input logic is_last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            elem_valid <= 1'b0;
            @(posedge clk);
        end
        elem_valid <= 1'b1;
        value      <= v;
        last       <= is_last;
        @(posedge clk);
        while (!elem_ready)
            @(posedge clk);
        board.take_element(v, is_last);
    endtask

    // Drop valid and hold off the sender until every expected sorted word has arrived.
    task automatic wait_for_drain();
        elem_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Values lean toward the extremes and a narrow band, so that ties and sign
    // boundaries come up often. Full-width random values exercise every bit.
    function automatic elem_t pick_value();
        case ($urandom_range(0, 9)) inside
            0:       return {1'b1, {(hs_pkg::DATA_W - 1){1'b0}}};
            1:       return {1'b0, {(hs_pkg::DATA_W - 1){1'b1}}};
            [2:4]:   return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Send a set of n elements with random content. Only the last one carries last.
    task automatic send_random_set(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_element(pick_value(), k + 1 == n);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned n;

        board              = new(CAPACITY);
        sender_idle_pct    = 34;
        receiver_stall_pct = 83;
        rst_n        <= 1'b0;
        elem_valid   <= 1'b0;
        value        <= '0;
        last         <= 1'b0;
        result_ready <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets. A mixed set holds both extremes, zero and the values next to
        // zero. Then come a single element, a set of equal values, an already
        // ascending set, a descending set and two pairs.
        send_element(32'sh7FFFFFFF, 1'b0);
        send_element(32'sh80000000, 1'b0);
        send_element(32'sd0,        1'b0);
        send_element(-32'sd1,       1'b0);
        send_element(32'sd1,        1'b1);
        send_element(32'sh80000000, 1'b1);
        for (int k = 0; k < 4; k++)
            send_element(32'sd7, k == 3);
        for (int k = -2; k < 2; k++)
            send_element(k, k == 1);
        for (int k = 3; k > -1; k--)
            send_element(k * 1000, k == 0);
        send_element(32'sh7FFFFFFF, 1'b0);
        send_element(32'sh7FFFFFFF, 1'b1);
        send_element(-32'sd5, 1'b0);
        send_element(32'sd5,  1'b1);

        // Random phases. The sender first idles less than the receiver stalls, then the
        // rates swap, and the last phase runs at full speed on both sides. Most sets are
        // small. The last phase adds one set a word longer than the store: the store
        // fills completely and the dropped word is the one with last.
        for (int phase = 0; phase < 3; phase++) begin
            wait_for_drain();
            sender_idle_pct    = (phase == 0) ? 34 : (phase == 1) ? 83 : 0;
            receiver_stall_pct = (phase == 0) ? 83 : (phase == 1) ? 34 : 0;
            sent = 0;
            while (sent < 4) begin
                n = $urandom_range(1, 8);
                send_random_set(n);
                sent += n;
            end
            if (phase == 2) begin
                send_random_set(CAPACITY + 1);
            end
        end

        // Let everything drain, then watch a little longer for stray words.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.note_error("sorted words still expected at the end of the run");

        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ heap_sorter_top.f @@
+incdir+sv
sv/hs_pkg.sv
sv/hs_datapath.sv
sv/hs_ctrl.sv
sv/heap_sorter_top.sv
tb/tb_top.sv
